>>> rtl/assert_macros.svh
// Assertion macros for the RTL files; vdm_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while the block is out of reset.
`define VDM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checks that the first condition implies the second in the following cycle.
`define VDM_ASSERT_NEXT(lbl, pre, post, msg) \
    `VDM_ASSERT(lbl, (pre) |=> (post), msg)

`endif

>>> rtl/vdm_pkg.sv
`default_nettype none
package vdm_pkg;

    localparam int QDEPTH = 256;
    localparam logic [15:0] LINK_END = 16'hFFFF;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOROOM  = 3'd1;
    localparam logic [2:0] ST_DROP    = 3'd2;
    localparam logic [2:0] ST_OVERRUN = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_BUILD = 2'd1;
    localparam logic [1:0] MODE_DROP  = 2'd2;

    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_LOAD    = 3'd1;
    localparam logic [2:0] OP_EVAL    = 3'd2;
    localparam logic [2:0] OP_ADD_FIN = 3'd3;
    localparam logic [2:0] OP_RC_STEP = 3'd4;
    localparam logic [2:0] OP_PUSH    = 3'd5;

    typedef struct packed {
        logic        cmd;
        logic [63:0] seg_addr;
        logic [31:0] seg_len;
        logic        seg_writable;
        logic        seg_last;
        logic [8:0]  chain_total;
        logic [31:0] cookie;
        logic [7:0]  used_id;
        logic [31:0] used_len;
        logic [15:0] device_used_idx;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  desc_index;
        logic        ring_publish;
        logic [7:0]  avail_slot;
        logic [15:0] avail_index_new;
        logic [31:0] cookie_out;
        logic [31:0] used_len_out;
        logic [8:0]  freed_count;
        logic [8:0]  free_count;
    } rsp_t;

    typedef struct packed {
        logic [2:0] op;
    } cmd_t;

    typedef struct packed {
        logic more;
        logic walk_end;
        logic rsp_free;
        logic is_reclaim;
        logic clr_busy;
    } sts_t;

    // Clamps to [2, 256] and rounds down to a power of two.
    function automatic logic [8:0] round_size(input logic [8:0] v);
        logic [8:0] p;
        begin
            p = 9'd2;
            for (int k = 2; k <= 8; k++)
            begin
                if (v >= (9'd1 << k)) p = 9'd1 << k;
            end
            return p;
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/vdm_ctrl.sv
`default_nettype none
module vdm_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire vdm_pkg::sts_t sts,
    output vdm_pkg::cmd_t    cmd
);
    `include "assert_macros.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;

    logic [2:0] state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE) && !sts.clr_busy;

    always_comb
    begin
        state_next = state_reg;
        cmd.op = vdm_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    cmd.op = vdm_pkg::OP_LOAD;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.op = vdm_pkg::OP_EVAL;
                if (!sts.more) state_next = S_PUSH;
                else if (sts.is_reclaim) state_next = S_WALK;
                else state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.op = vdm_pkg::OP_ADD_FIN;
                state_next = S_PUSH;
            end
            S_WALK:
            begin
                cmd.op = vdm_pkg::OP_RC_STEP;
                if (sts.walk_end) state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.op = vdm_pkg::OP_PUSH;
                if (sts.rsp_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    `VDM_ASSERT_NEXT(a_accept_eval, req_valid && req_ready, state_reg == S_EVAL,
        "accepted request did not enter evaluation")
    `VDM_ASSERT_NEXT(a_add_push, state_reg == S_ADD, state_reg == S_PUSH,
        "add completion did not move to push")
    `VDM_ASSERT_NEXT(a_push_idle, state_reg == S_PUSH && sts.rsp_free,
        state_reg == S_IDLE, "push with free output did not return to idle")

endmodule
`default_nettype wire

>>> rtl/vdm_dp.sv
`default_nettype none
module vdm_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire vdm_pkg::cmd_t cmd,
    output vdm_pkg::sts_t      sts,
    input  wire vdm_pkg::req_t req,
    output vdm_pkg::rsp_t      rsp,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    input  wire logic          cfg_we,
    input  wire logic [8:0]    cfg_wdata
);
    // Descriptor stores; a clearing pass after reset or a size write restores them.
    logic [15:0] link_mem [vdm_pkg::QDEPTH];
    logic        flag_mem [vdm_pkg::QDEPTH];
    logic [31:0] ck_mem   [vdm_pkg::QDEPTH];

    logic [8:0]  qsize_reg, qsize_next;
    logic [15:0] fhead_reg, fhead_next;
    logic [8:0]  ftot_reg, ftot_next;
    logic [15:0] avail_reg, avail_next;
    logic [15:0] used_reg, used_next;
    logic [15:0] cursor_reg, cursor_next;
    logic [15:0] chead_reg, chead_next;
    logic [8:0]  seen_reg, seen_next;
    logic [1:0]  mode_reg, mode_next;
    logic [8:0]  cnt_reg, cnt_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic [7:0]  clr_reg, clr_next;
    logic        clr_busy_reg, clr_busy_next;
    vdm_pkg::req_t req_reg;
    vdm_pkg::rsp_t res_reg, res_next, rsp_reg, rsp_next;

    logic [15:0] link_q_reg;
    logic        flag_q_reg;
    logic [31:0] ck_q_reg;
    logic [7:0]  rd_idx_reg;

    logic [7:0]  rd_addr;
    logic        link_we, flag_we, ck_we, flag_wd;
    logic [7:0]  link_wa, flag_wa, ck_wa;
    logic [15:0] link_wd;
    logic [31:0] ck_wd;

    logic [15:0] link_eff;
    logic        flag_eff;
    logic [31:0] ck_eff;
    logic [8:0]  clr_link;

    assign clr_link = {1'b0, clr_reg} + 9'd1;
    assign link_eff = link_q_reg;
    assign flag_eff = flag_q_reg;
    assign ck_eff   = ck_q_reg;

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        logic        start, last;
        logic [8:0]  total, cnt_n, qmask;
        logic [15:0] head_e, idx_e;
        logic [8:0]  seen_e;
        logic [9:0]  sum;
        qsize_next = qsize_reg;  fhead_next = fhead_reg;  ftot_next = ftot_reg;
        avail_next = avail_reg;  used_next = used_reg;    cursor_next = cursor_reg;
        chead_next = chead_reg;  seen_next = seen_reg;    mode_next = mode_reg;
        cnt_next = cnt_reg;      res_next = res_reg;      rsp_next = rsp_reg;
        clr_next = clr_reg;      clr_busy_next = clr_busy_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rd_addr = '0;
        link_we = 1'b0; link_wa = '0; link_wd = '0;
        flag_we = 1'b0; flag_wa = '0; flag_wd = 1'b0;
        ck_we = 1'b0;   ck_wa = '0;   ck_wd = '0;
        sts.more = 1'b0;
        sts.walk_end = 1'b0;
        sts.rsp_free = !rsp_valid_reg || rsp_ready;
        sts.is_reclaim = req_reg.cmd;
        sts.clr_busy = clr_busy_reg;
        last   = req_reg.seg_last;
        start  = (mode_reg != vdm_pkg::MODE_BUILD);
        total  = (req_reg.chain_total == 9'd0) ? 9'd1 : req_reg.chain_total;
        head_e = start ? fhead_reg : chead_reg;
        idx_e  = start ? fhead_reg : cursor_reg;
        seen_e = start ? 9'd0 : seen_reg;
        cnt_n  = cnt_reg + 9'd1;
        qmask  = qsize_reg - 9'd1;
        sum    = '0;
        unique case (cmd.op)
            vdm_pkg::OP_EVAL:
            begin
                res_next = '0;
                if (!req_reg.cmd)
                begin
                    if (mode_reg == vdm_pkg::MODE_DROP)
                    begin
                        res_next.status = vdm_pkg::ST_DROP;
                        if (last) mode_next = vdm_pkg::MODE_IDLE;
                    end
                    else if (start && ftot_reg < total)
                    begin
                        res_next.status = vdm_pkg::ST_NOROOM;
                        mode_next = last ? vdm_pkg::MODE_IDLE : vdm_pkg::MODE_DROP;
                    end
                    else if (ftot_reg == 9'd0 || idx_e >= {7'd0, qsize_reg})
                    begin
                        // Out of descriptors mid-chain: hand the partial chain back.
                        fhead_next = head_e;
                        sum = {1'b0, ftot_reg} + {1'b0, seen_e};
                        ftot_next = (sum > {1'b0, qsize_reg}) ? qsize_reg : sum[8:0];
                        seen_next = '0;
                        chead_next = head_e;
                        cursor_next = idx_e;
                        mode_next = last ? vdm_pkg::MODE_IDLE : vdm_pkg::MODE_DROP;
                        res_next.status = vdm_pkg::ST_OVERRUN;
                    end
                    else
                    begin
                        chead_next = head_e;
                        cursor_next = idx_e;
                        seen_next = seen_e;
                        mode_next = vdm_pkg::MODE_BUILD;
                        if (seen_e == 9'd0)
                        begin
                            ck_we = 1'b1; ck_wa = idx_e[7:0]; ck_wd = req_reg.cookie;
                        end
                        flag_we = 1'b1; flag_wa = idx_e[7:0]; flag_wd = !last;
                        rd_addr = idx_e[7:0];
                        res_next.desc_index = idx_e[7:0];
                        sts.more = 1'b1;
                    end
                end
                else
                begin
                    if (mode_reg == vdm_pkg::MODE_BUILD ||
                        used_reg == req_reg.device_used_idx)
                    begin
                        res_next.status = vdm_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        used_next = used_reg + 16'd1;
                        if ({1'b0, req_reg.used_id} >= qsize_reg)
                        begin
                            res_next.status = vdm_pkg::ST_OVERRUN;
                        end
                        else
                        begin
                            rd_addr = req_reg.used_id;
                            cnt_next = '0;
                            res_next.desc_index = req_reg.used_id;
                            res_next.used_len_out = req_reg.used_len;
                            sts.more = 1'b1;
                        end
                    end
                end
            end
            vdm_pkg::OP_ADD_FIN:
            begin
                fhead_next = link_eff;
                cursor_next = link_eff;
                ftot_next = ftot_reg - 9'd1;
                seen_next = seen_reg + 9'd1;
                if (last)
                begin
                    res_next.ring_publish = 1'b1;
                    res_next.avail_slot = avail_reg[7:0] & qmask[7:0];
                    res_next.avail_index_new = avail_reg + 16'd1;
                    avail_next = avail_reg + 16'd1;
                    mode_next = vdm_pkg::MODE_IDLE;
                end
            end
            vdm_pkg::OP_RC_STEP:
            begin
                cnt_next = cnt_n;
                if (!flag_eff || cnt_n >= qsize_reg || link_eff >= {7'd0, qsize_reg})
                begin
                    // Chain tail, count limit or out-of-range link: splice the chain onto the free list.
                    sts.walk_end = 1'b1;
                    link_we = 1'b1; link_wa = rd_idx_reg; link_wd = fhead_reg;
                    fhead_next = {8'd0, req_reg.used_id};
                    sum = {1'b0, ftot_reg} + {1'b0, cnt_n};
                    ftot_next = (sum > {1'b0, qsize_reg}) ? qsize_reg : sum[8:0];
                    ck_we = 1'b1; ck_wa = req_reg.used_id; ck_wd = '0;
                    res_next.cookie_out = ck_eff;
                    res_next.freed_count = cnt_n;
                end
                else
                begin
                    rd_addr = link_eff[7:0];
                end
            end
            vdm_pkg::OP_PUSH:
            begin
                if (sts.rsp_free)
                begin
                    rsp_next = res_reg;
                    rsp_next.free_count = ftot_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (clr_busy_reg)
        begin
            // Clearing pass: one entry of every store per cycle; no new request is accepted.
            link_we = 1'b1;
            link_wa = clr_reg;
            link_wd = (clr_link < qsize_reg) ? {7'd0, clr_link} : vdm_pkg::LINK_END;
            flag_we = 1'b1; flag_wa = clr_reg; flag_wd = 1'b0;
            ck_we = 1'b1;   ck_wa = clr_reg;   ck_wd = '0;
            clr_next = clr_reg + 8'd1;
            if (clr_reg == 8'(vdm_pkg::QDEPTH - 1)) clr_busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qsize_reg <= 9'd256;   fhead_reg <= '0;   ftot_reg <= 9'd256;
            avail_reg <= '0;       used_reg <= '0;    cursor_reg <= '0;
            chead_reg <= '0;       seen_reg <= '0;    mode_reg <= vdm_pkg::MODE_IDLE;
            cnt_reg <= '0;         rsp_valid_reg <= 1'b0;
            clr_reg <= '0;         clr_busy_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            qsize_reg <= vdm_pkg::round_size(cfg_wdata);
            ftot_reg <= vdm_pkg::round_size(cfg_wdata);
            fhead_reg <= '0;       avail_reg <= '0;   used_reg <= '0;
            cursor_reg <= '0;      chead_reg <= '0;   seen_reg <= '0;
            mode_reg <= vdm_pkg::MODE_IDLE;
            cnt_reg <= '0;         rsp_valid_reg <= rsp_valid_next;
            clr_reg <= '0;         clr_busy_reg <= 1'b1;
        end
        else
        begin
            qsize_reg <= qsize_next;   fhead_reg <= fhead_next;   ftot_reg <= ftot_next;
            avail_reg <= avail_next;   used_reg <= used_next;     cursor_reg <= cursor_next;
            chead_reg <= chead_next;   seen_reg <= seen_next;     mode_reg <= mode_next;
            cnt_reg <= cnt_next;       rsp_valid_reg <= rsp_valid_next;
            clr_reg <= clr_next;       clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == vdm_pkg::OP_LOAD) req_reg <= req;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
        if (link_we) link_mem[link_wa] <= link_wd;
        if (flag_we) flag_mem[flag_wa] <= flag_wd;
        if (ck_we) ck_mem[ck_wa] <= ck_wd;
        link_q_reg  <= link_mem[rd_addr];
        flag_q_reg  <= flag_mem[rd_addr];
        rd_idx_reg  <= rd_addr;
        ck_q_reg    <= ck_mem[req_reg.used_id];
    end

endmodule
`default_nettype wire

>>> rtl/virtqueue_descriptor_manager_top.sv
// Descriptor manager for one split virtqueue, driver side.
// Requests enter on req/req_valid/req_ready and each gives exactly one
// response on rsp/rsp_valid/rsp_ready. A request is taken only while the
// block is idle; it then works on that request alone.
// An add request goes through evaluation, the registered link read and the
// response register before its response is valid. Requests that are refused,
// dropped or find nothing to reclaim skip the link read and go from
// evaluation straight to the response register. A reclaim walks the chain
// one descriptor per cycle through the same link memory port.
// The block returns to idle as the response is registered, so the next
// request can be accepted while that response still waits for rsp_ready; a
// stalled receiver only holds the block once a second response is ready.
// Reset, or any write of cfg_wdata with cfg_we, sets the queue size (256 at
// reset), rebuilds the free list and clears all counters. A clearing pass then
// rewrites the descriptor stores to their reset contents, one entry per
// cycle, and req_ready stays low until it is done.
`default_nettype none
module virtqueue_descriptor_manager_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire vdm_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output vdm_pkg::rsp_t      rsp,
    input  wire logic          cfg_we,
    input  wire logic [8:0]    cfg_wdata
);
    vdm_pkg::cmd_t cmd;
    vdm_pkg::sts_t sts;

    // The controller sequences each request; the datapath holds all queue state.
    vdm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    vdm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

endmodule
`default_nettype wire
